// ===== design/mel_pkg.sv =====
// Shared types, character codes and classifier functions for the expression lexer.
package mel_pkg;

    localparam int POSITION_BITS_DEF = 16;
    localparam int MANTISSA_BITS_DEF = 48;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        KIND_OP      = 4'd0,
        KIND_FUNC    = 4'd1,
        KIND_COMMA   = 4'd2,
        KIND_OPEN    = 4'd3,
        KIND_CLOSE   = 4'd4,
        KIND_NUMBER  = 4'd5,
        KIND_VAR     = 4'd6,
        KIND_INVALID = 4'd7,
        KIND_END     = 4'd8
    } kind_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_CARET  = "^";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_PCT    = "%";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_QMARK  = "?";
    localparam logic [7:0] CH_COLON  = ":";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_LBRACK = "[";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_RBRACK = "]";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_E_LO   = "e";
    localparam logic [7:0] CH_E_UP   = "E";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_NINE   = "9";
    localparam logic [7:0] CH_A_LO   = "a";
    localparam logic [7:0] CH_Z_LO   = "z";
    localparam logic [7:0] CH_A_UP   = "A";
    localparam logic [7:0] CH_Z_UP   = "Z";

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        lead;
        logic [7:0]        eq_count;
        logic [7:0]        frac;
        logic signed [15:0] exponent;
        logic              overflow;
        logic              last;
    } tok_fix_t;

    localparam int TOK_FIX_W = $bits(tok_fix_t);

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_A_LO) && (c <= CH_Z_LO)) || ((c >= CH_A_UP) && (c <= CH_Z_UP));
    endfunction

    function automatic logic is_oper(input logic [7:0] c);
        logic r;
        unique case (c)
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_CARET, CH_BANG,
            CH_PCT, CH_LT, CH_GT, CH_EQ, CH_QMARK, CH_COLON: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_open(input logic [7:0] c);
        return (c == CH_LPAREN) || (c == CH_LBRACK) || (c == CH_LBRACE);
    endfunction

    function automatic logic is_close(input logic [7:0] c);
        return (c == CH_RPAREN) || (c == CH_RBRACK) || (c == CH_RBRACE);
    endfunction

endpackage

// ===== design/math_expression_lexer.sv =====
// Expression lexer top level: input byte register, scanner step and token queue.
// Takes one text byte per cycle while the token queue has room, and emits
// tokens (operators, brackets, commas, identifiers, functions, numbers, invalid
// bytes and end) on the result channel. An accepted byte sits in the input
// register until it is scanned, and its tokens are written into the token queue.
// Throughput is one byte per cycle; a byte that both closes a pending token and
// emits its own puts two tokens into the four-entry token queue, and the input
// stalls only while that queue holds more than two tokens. Numbers come out as
// a decimal mantissa, a fraction digit count and a signed exponent.
module math_expression_lexer #(
    parameter int POSITION_BITS = mel_pkg::POSITION_BITS_DEF,
    parameter int MANTISSA_BITS = mel_pkg::MANTISSA_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                char_code,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [3:0]                token_kind,
    output logic [POSITION_BITS-1:0]  start_pos,
    output logic [POSITION_BITS-1:0]  token_length,
    output logic [7:0]                lead_char,
    output logic [7:0]                equals_count,
    output logic [MANTISSA_BITS-1:0]  mantissa,
    output logic [7:0]                frac_digits,
    output logic signed [15:0]        exponent,
    output logic                      number_overflow,
    output logic                      last_of_input
);

    localparam int DATA_W = mel_pkg::TOK_FIX_W + 2 * POSITION_BITS + MANTISSA_BITS;
    localparam int PW     = mel_pkg::QPTR_W;

    logic                     hold_valid_reg, hold_valid_next;
    logic [7:0]               char_reg;
    logic                     accept;
    logic                     room;
    logic                     step;
    logic [1:0]               emit_count;
    mel_pkg::tok_fix_t        tok0_fix, tok1_fix, head_fix;
    logic [POSITION_BITS-1:0] tok0_start, tok0_len, tok1_start, tok1_len;
    logic [MANTISSA_BITS-1:0] tok0_mant, tok1_mant;
    logic [DATA_W-1:0]        push0_data, push1_data, head_data;
    logic [PW:0]              q_count;
    logic                     pop;

    assign room     = q_count <= (PW+1)'(mel_pkg::QUEUE_DEPTH - 2);
    assign step     = hold_valid_reg && room;
    assign in_stall = hold_valid_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        hold_valid_next = accept ? 1'b1 : (step ? 1'b0 : hold_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_code;
        end
    end

    mel_scan #(
        .POSITION_BITS (POSITION_BITS),
        .MANTISSA_BITS (MANTISSA_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .char_in    (char_reg),
        .emit_count (emit_count),
        .tok0_fix   (tok0_fix),
        .tok0_start (tok0_start),
        .tok0_len   (tok0_len),
        .tok0_mant  (tok0_mant),
        .tok1_fix   (tok1_fix),
        .tok1_start (tok1_start),
        .tok1_len   (tok1_len),
        .tok1_mant  (tok1_mant)
    );

    assign push0_data = {tok0_fix, tok0_start, tok0_len, tok0_mant};
    assign push1_data = {tok1_fix, tok1_start, tok1_len, tok1_mant};

    mel_tokq #(
        .DATA_W (DATA_W)
    ) u_tokq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (emit_count),
        .push0_data (push0_data),
        .push1_data (push1_data),
        .pop        (pop),
        .head_data  (head_data),
        .count      (q_count)
    );

    assign out_valid = q_count != '0;
    assign pop       = out_valid && !out_stall;

    assign {head_fix, start_pos, token_length, mantissa} = head_data;

    assign token_kind      = head_fix.kind;
    assign lead_char       = head_fix.lead;
    assign equals_count    = head_fix.eq_count;
    assign frac_digits     = head_fix.frac;
    assign exponent        = head_fix.exponent;
    assign number_overflow = head_fix.overflow;
    assign last_of_input   = head_fix.last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= (PW+1)'(mel_pkg::QUEUE_DEPTH))
        else $error("token queue overfilled");

    a_double_emit_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (emit_count == 2'd2)) |=> out_valid)
        else $error("two tokens written but result channel empty");

    a_partner_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !last_of_input) |=> out_valid)
        else $error("second token of a byte missing after transfer");

    a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && in_stall) |=> hold_valid_reg && $stable(char_reg))
        else $error("held byte lost while queue full");

endmodule

// ===== design/mel_scan.sv =====
// Scanner state and per-byte step logic: extends the pending token or emits up to two tokens.
module mel_scan #(
    parameter int POSITION_BITS = mel_pkg::POSITION_BITS_DEF,
    parameter int MANTISSA_BITS = mel_pkg::MANTISSA_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  logic [7:0]               char_in,
    output logic [1:0]               emit_count,
    output mel_pkg::tok_fix_t        tok0_fix,
    output logic [POSITION_BITS-1:0] tok0_start,
    output logic [POSITION_BITS-1:0] tok0_len,
    output logic [MANTISSA_BITS-1:0] tok0_mant,
    output mel_pkg::tok_fix_t        tok1_fix,
    output logic [POSITION_BITS-1:0] tok1_start,
    output logic [POSITION_BITS-1:0] tok1_len,
    output logic [MANTISSA_BITS-1:0] tok1_mant
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_OP,
        MODE_IDENT,
        MODE_INT,
        MODE_FRAC,
        MODE_ESIGN,
        MODE_EDIG
    } mode_t;

    localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
    localparam logic [MANTISSA_BITS-1:0] MANT_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE  = POSITION_BITS'(1);

    mode_t                     mode_reg, mode_next;
    logic [POSITION_BITS-1:0]  pos_reg, pos_next;
    logic [POSITION_BITS-1:0]  tstart_reg, tstart_next;
    logic [POSITION_BITS-1:0]  tlen_reg, tlen_next;
    logic [7:0]                first_reg, first_next;
    logic [7:0]                eq_reg, eq_next;
    logic [MANTISSA_BITS-1:0]  dv_reg, dv_next;
    logic [7:0]                frac_reg, frac_next;
    logic [14:0]               mag_reg, mag_next;
    logic                      neg_reg, neg_next;
    logic                      ovf_reg, ovf_next;

    logic [7:0]                c;
    logic [3:0]                d;
    logic                      dig;
    logic                      is_e;
    logic                      ext;
    logic [MANTISSA_BITS+3:0]  mant_wide;
    logic                      mant_sat;
    logic [MANTISSA_BITS-1:0]  mant_add;
    logic [18:0]               exp_wide;
    logic                      exp_sat;
    logic [14:0]               exp_add;
    logic [POSITION_BITS-1:0]  pos_inc;
    logic [POSITION_BITS-1:0]  len_inc;
    logic [POSITION_BITS:0]    op_len_w;
    logic [POSITION_BITS-1:0]  op_len;
    logic signed [15:0]        exp_pos;

    logic                      a_v, b_v;
    mel_pkg::tok_fix_t         a_fix, b_fix;
    logic [POSITION_BITS-1:0]  a_start, a_len, b_start, b_len;
    logic [MANTISSA_BITS-1:0]  a_mant;

    always_comb
    begin
        c        = char_in;
        d        = c[3:0];
        dig      = mel_pkg::is_digit(c);
        is_e     = (c == mel_pkg::CH_E_LO) || (c == mel_pkg::CH_E_UP);

        mant_wide = ({4'b0, dv_reg} << 3) + ({4'b0, dv_reg} << 1)
                  + (MANTISSA_BITS+4)'(d);
        mant_sat  = |mant_wide[MANTISSA_BITS+3:MANTISSA_BITS];
        mant_add  = mant_sat ? MANT_MAX : mant_wide[MANTISSA_BITS-1:0];

        exp_wide  = ({4'b0, mag_reg} << 3) + ({4'b0, mag_reg} << 1) + 19'(d);
        exp_sat   = exp_wide > 19'd32767;
        exp_add   = exp_sat ? 15'h7FFF : exp_wide[14:0];

        pos_inc   = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + POS_ONE;
        len_inc   = (tlen_reg == POS_MAX) ? POS_MAX : tlen_reg + POS_ONE;

        op_len_w  = (POSITION_BITS+1)'({1'b0, eq_reg}) + (POSITION_BITS+1)'(1);
        op_len    = op_len_w[POSITION_BITS] ? POS_MAX : op_len_w[POSITION_BITS-1:0];

        exp_pos   = signed'({1'b0, mag_reg});

        mode_next   = mode_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        tlen_next   = tlen_reg;
        first_next  = first_reg;
        eq_next     = eq_reg;
        dv_next     = dv_reg;
        frac_next   = frac_reg;
        mag_next    = mag_reg;
        neg_next    = neg_reg;
        ovf_next    = ovf_reg;

        ext = 1'b0;
        unique case (mode_reg)
            MODE_IDLE:
            begin
                ext = 1'b0;
            end
            MODE_OP:
            begin
                if (c == mel_pkg::CH_EQ)
                begin
                    ext = 1'b1;
                    if (eq_reg != 8'hFF)
                    begin
                        eq_next = eq_reg + 8'd1;
                    end
                end
            end
            MODE_IDENT:
            begin
                ext = mel_pkg::is_alpha(c) || dig || (c == mel_pkg::CH_UNDER);
            end
            MODE_INT:
            begin
                priority if (dig)
                begin
                    ext      = 1'b1;
                    dv_next  = mant_add;
                    ovf_next = ovf_reg | mant_sat;
                end
                else if (c == mel_pkg::CH_DOT)
                begin
                    ext       = 1'b1;
                    mode_next = MODE_FRAC;
                end
                else if (is_e)
                begin
                    ext       = 1'b1;
                    mode_next = MODE_ESIGN;
                end
                else
                begin
                    ext = 1'b0;
                end
            end
            MODE_FRAC:
            begin
                priority if (dig)
                begin
                    ext       = 1'b1;
                    dv_next   = mant_add;
                    ovf_next  = ovf_reg | mant_sat | (frac_reg == 8'hFF);
                    frac_next = (frac_reg == 8'hFF) ? frac_reg : frac_reg + 8'd1;
                end
                else if (is_e)
                begin
                    ext       = 1'b1;
                    mode_next = MODE_ESIGN;
                end
                else
                begin
                    ext = 1'b0;
                end
            end
            MODE_ESIGN:
            begin
                priority if (c == mel_pkg::CH_PLUS)
                begin
                    ext       = 1'b1;
                    mode_next = MODE_EDIG;
                end
                else if (c == mel_pkg::CH_MINUS)
                begin
                    ext       = 1'b1;
                    neg_next  = 1'b1;
                    mode_next = MODE_EDIG;
                end
                else if (dig)
                begin
                    ext       = 1'b1;
                    mag_next  = exp_add;
                    ovf_next  = ovf_reg | exp_sat;
                    mode_next = MODE_EDIG;
                end
                else
                begin
                    ext = 1'b0;
                end
            end
            MODE_EDIG:
            begin
                if (dig)
                begin
                    ext      = 1'b1;
                    mag_next = exp_add;
                    ovf_next = ovf_reg | exp_sat;
                end
            end
            default:
            begin
                ext = 1'b0;
            end
        endcase

        // pending token closed by this byte
        a_v     = 1'b0;
        a_fix   = '0;
        a_start = tstart_reg;
        a_len   = tlen_reg;
        a_mant  = '0;
        if (!ext && (mode_reg != MODE_IDLE))
        begin
            a_v = 1'b1;
            priority if (mode_reg == MODE_OP)
            begin
                a_fix.kind     = mel_pkg::KIND_OP;
                a_fix.lead     = first_reg;
                a_fix.eq_count = eq_reg;
                a_len          = op_len;
            end
            else if (mode_reg == MODE_IDENT)
            begin
                a_fix.kind = mel_pkg::is_open(c) ? mel_pkg::KIND_FUNC : mel_pkg::KIND_VAR;
            end
            else
            begin
                a_fix.kind     = mel_pkg::KIND_NUMBER;
                a_fix.frac     = frac_reg;
                a_fix.exponent = neg_reg ? -exp_pos : exp_pos;
                a_fix.overflow = ovf_reg;
                a_mant         = dv_reg;
            end
        end

        // the byte itself, when not absorbed
        b_v     = 1'b0;
        b_fix   = '0;
        b_start = pos_reg;
        b_len   = POS_ONE;
        if (ext)
        begin
            tlen_next = len_inc;
            pos_next  = pos_inc;
        end
        else
        begin
            mode_next = MODE_IDLE;
            if (c == mel_pkg::CH_NUL)
            begin
                b_v        = 1'b1;
                b_fix.kind = mel_pkg::KIND_END;
                b_len      = '0;
                pos_next   = '0;
            end
            else
            begin
                pos_next = pos_inc;
                priority if (c == mel_pkg::CH_SPACE)
                begin
                    b_v = 1'b0;
                end
                else if (mel_pkg::is_oper(c))
                begin
                    mode_next   = MODE_OP;
                    first_next  = c;
                    eq_next     = '0;
                    tstart_next = pos_reg;
                    tlen_next   = POS_ONE;
                end
                else if (mel_pkg::is_open(c))
                begin
                    b_v        = 1'b1;
                    b_fix.kind = mel_pkg::KIND_OPEN;
                    b_fix.lead = c;
                end
                else if (mel_pkg::is_close(c))
                begin
                    b_v        = 1'b1;
                    b_fix.kind = mel_pkg::KIND_CLOSE;
                    b_fix.lead = c;
                end
                else if (c == mel_pkg::CH_COMMA)
                begin
                    b_v        = 1'b1;
                    b_fix.kind = mel_pkg::KIND_COMMA;
                end
                else if (mel_pkg::is_alpha(c))
                begin
                    mode_next   = MODE_IDENT;
                    tstart_next = pos_reg;
                    tlen_next   = POS_ONE;
                end
                else if (dig || (c == mel_pkg::CH_DOT))
                begin
                    mode_next   = dig ? MODE_INT : MODE_FRAC;
                    tstart_next = pos_reg;
                    tlen_next   = POS_ONE;
                    dv_next     = dig ? MANTISSA_BITS'(d) : '0;
                    frac_next   = '0;
                    mag_next    = '0;
                    neg_next    = 1'b0;
                    ovf_next    = 1'b0;
                end
                else
                begin
                    b_v        = 1'b1;
                    b_fix.kind = mel_pkg::KIND_INVALID;
                    b_fix.lead = c;
                end
            end
        end

        emit_count    = step ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
        tok0_fix      = a_v ? a_fix : b_fix;
        tok0_fix.last = !(a_v && b_v);
        tok0_start    = a_v ? a_start : b_start;
        tok0_len      = a_v ? a_len : b_len;
        tok0_mant     = a_v ? a_mant : '0;
        tok1_fix      = b_fix;
        tok1_fix.last = 1'b1;
        tok1_start    = b_start;
        tok1_len      = b_len;
        tok1_mant     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            tlen_reg   <= '0;
            first_reg  <= '0;
            eq_reg     <= '0;
            dv_reg     <= '0;
            frac_reg   <= '0;
            mag_reg    <= '0;
            neg_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            tstart_reg <= tstart_next;
            tlen_reg   <= tlen_next;
            first_reg  <= first_next;
            eq_reg     <= eq_next;
            dv_reg     <= dv_next;
            frac_reg   <= frac_next;
            mag_reg    <= mag_next;
            neg_reg    <= neg_next;
            ovf_reg    <= ovf_next;
        end
    end

endmodule

// ===== design/mel_tokq.sv =====
// Small token queue: takes up to two tokens per cycle, hands out one per transfer.
module mel_tokq #(
    parameter int DATA_W = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [1:0]                push_count,
    input  logic [DATA_W-1:0]         push0_data,
    input  logic [DATA_W-1:0]         push1_data,
    input  logic                      pop,
    output logic [DATA_W-1:0]         head_data,
    output logic [mel_pkg::QPTR_W:0]  count
);

    localparam int PW = mel_pkg::QPTR_W;

    logic [DATA_W-1:0] entries_reg [mel_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg, count_next;
    logic [PW-1:0]     wr_ptr_plus1;

    always_comb
    begin
        wr_ptr_plus1 = wr_ptr_reg + PW'(1);
        wr_ptr_next  = wr_ptr_reg + PW'(push_count);
        rd_ptr_next  = rd_ptr_reg + PW'(pop);
        count_next   = count_reg + (PW+1)'(push_count) - (PW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push0_data;
        end
        if (push_count == 2'd2)
        begin
            entries_reg[wr_ptr_plus1] <= push1_data;
        end
    end

    assign head_data = entries_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for math_expression_lexer: byte stream in, token stream checked against a scanner model.
`timescale 1ns / 100ps

module tb_top;

    localparam int POS_W  = mel_pkg::POSITION_BITS_DEF;
    localparam int MANT_W = mel_pkg::MANTISSA_BITS_DEF;
    localparam longint unsigned MANT_MAX = (64'd1 << MANT_W) - 1;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_OP, SCAN_IDENT, SCAN_INT, SCAN_FRAC, SCAN_ESIGN, SCAN_EDIG
    } scan_t;

    typedef enum logic [3:0] {
        CLS_NUL, CLS_SPACE, CLS_DIGIT, CLS_ALPHA, CLS_OPER,
        CLS_OPEN, CLS_CLOSE, CLS_COMMA, CLS_DOT, CLS_OTHER
    } char_cls_t;

    typedef struct packed {
        mel_pkg::kind_t     kind;
        logic [POS_W-1:0]   start;
        logic [POS_W-1:0]   len;
        logic [7:0]         lead;
        logic [7:0]         eq;
        logic [MANT_W-1:0]  mant;
        logic [7:0]         frac;
        logic signed [15:0] expo;
        logic               ovf;
        logic               last;
    } token_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] char_code = 8'h00;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [3:0] token_kind;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] token_length;
    logic [7:0] lead_char;
    logic [7:0] equals_count;
    logic [MANT_W-1:0] mantissa;
    logic [7:0] frac_digits;
    logic signed [15:0] exponent;
    logic number_overflow;
    logic last_of_input;

    math_expression_lexer u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .char_code       (char_code),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .token_kind      (token_kind),
        .start_pos       (start_pos),
        .token_length    (token_length),
        .lead_char       (lead_char),
        .equals_count    (equals_count),
        .mantissa        (mantissa),
        .frac_digits     (frac_digits),
        .exponent        (exponent),
        .number_overflow (number_overflow),
        .last_of_input   (last_of_input)
    );

    logic [7:0] text_q[$];
    token_t     token_q[$];
    logic       quiet = 1'b0;
    int         gap_cnt = 0;
    int         hold_cnt = 0;
    int         mismatch_count = 0;
    int         pushed_bytes = 0;
    string      oper_text = "+-*/^!%<>=?:";

    // scanner state
    scan_t              sc_mode = SCAN_IDLE;
    logic [POS_W-1:0]   sc_pos = '0;
    logic [POS_W-1:0]   sc_start = '0;
    logic [POS_W-1:0]   sc_len = '0;
    logic [7:0]         sc_first = '0;
    logic [7:0]         sc_eqrun = '0;
    logic [MANT_W-1:0]  sc_mant = '0;
    logic [7:0]         sc_frac = '0;
    logic [14:0]        sc_emag = '0;
    logic               sc_eneg = 1'b0;
    logic               sc_ovf = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic char_cls_t classify(input logic [7:0] c);
        char_cls_t r;
        if (c >= mel_pkg::CH_ZERO && c <= mel_pkg::CH_NINE)
            r = CLS_DIGIT;
        else if ((c >= mel_pkg::CH_A_LO && c <= mel_pkg::CH_Z_LO)
                 || (c >= mel_pkg::CH_A_UP && c <= mel_pkg::CH_Z_UP))
            r = CLS_ALPHA;
        else
        begin
            case (c)
                mel_pkg::CH_NUL:   r = CLS_NUL;
                mel_pkg::CH_SPACE: r = CLS_SPACE;
                mel_pkg::CH_COMMA: r = CLS_COMMA;
                mel_pkg::CH_DOT:   r = CLS_DOT;
                mel_pkg::CH_PLUS, mel_pkg::CH_MINUS, mel_pkg::CH_STAR, mel_pkg::CH_SLASH,
                mel_pkg::CH_CARET, mel_pkg::CH_BANG, mel_pkg::CH_PCT, mel_pkg::CH_LT,
                mel_pkg::CH_GT, mel_pkg::CH_EQ, mel_pkg::CH_QMARK, mel_pkg::CH_COLON:
                    r = CLS_OPER;
                mel_pkg::CH_LPAREN, mel_pkg::CH_LBRACK, mel_pkg::CH_LBRACE: r = CLS_OPEN;
                mel_pkg::CH_RPAREN, mel_pkg::CH_RBRACK, mel_pkg::CH_RBRACE: r = CLS_CLOSE;
                default:           r = CLS_OTHER;
            endcase
        end
        return r;
    endfunction

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic token_t plain_token(input mel_pkg::kind_t k,
                                           input logic [POS_W-1:0] st,
                                           input logic [POS_W-1:0] ln,
                                           input logic [7:0] ld, input logic [7:0] eq);
        token_t t;
        t = '0;
        t.kind  = k;
        t.start = st;
        t.len   = ln;
        t.lead  = ld;
        t.eq    = eq;
        return t;
    endfunction

    function automatic token_t number_token();
        token_t t;
        t = plain_token(mel_pkg::KIND_NUMBER, sc_start, sc_len, 8'h00, 8'h00);
        t.mant = sc_mant;
        t.frac = sc_frac;
        t.expo = sc_eneg ? 16'sh0 - $signed({1'b0, sc_emag}) : $signed({1'b0, sc_emag});
        t.ovf  = sc_ovf;
        return t;
    endfunction

    task automatic add_digit(input logic [7:0] d);
        longint unsigned m;
        m = sc_mant;
        if (m > (MANT_MAX - d) / 10)
        begin
            sc_mant = MANT_MAX[MANT_W-1:0];
            sc_ovf  = 1'b1;
        end
        else
            sc_mant = MANT_W'(m * 10 + d);
    endtask

    task automatic add_exp_digit(input logic [7:0] d);
        int unsigned v;
        v = sc_emag * 10 + d;
        if (v > 32767)
        begin
            v = 32767;
            sc_ovf = 1'b1;
        end
        sc_emag = v[14:0];
    endtask

    task automatic begin_number(input logic [POS_W-1:0] p);
        sc_start = p;
        sc_len   = POS_W'(1);
        sc_mant  = '0;
        sc_frac  = '0;
        sc_emag  = '0;
        sc_eneg  = 1'b0;
        sc_ovf   = 1'b0;
    endtask

    task automatic try_extend(input logic [7:0] c, input char_cls_t cls, output logic taken);
        logic dig;
        dig = (cls == CLS_DIGIT);
        taken = 1'b0;
        case (sc_mode)
            SCAN_OP:
                if (c == mel_pkg::CH_EQ)
                begin
                    if (sc_eqrun != 8'hFF) sc_eqrun = sc_eqrun + 1'b1;
                    taken = 1'b1;
                end
            SCAN_IDENT:
                taken = (cls == CLS_ALPHA) || dig || (c == mel_pkg::CH_UNDER);
            SCAN_INT:
                if (dig)
                begin
                    add_digit(c - mel_pkg::CH_ZERO);
                    taken = 1'b1;
                end
                else if (c == mel_pkg::CH_DOT)
                begin
                    sc_mode = SCAN_FRAC;
                    taken = 1'b1;
                end
                else if (c == mel_pkg::CH_E_LO || c == mel_pkg::CH_E_UP)
                begin
                    sc_mode = SCAN_ESIGN;
                    taken = 1'b1;
                end
            SCAN_FRAC:
                if (dig)
                begin
                    add_digit(c - mel_pkg::CH_ZERO);
                    if (sc_frac == 8'hFF) sc_ovf = 1'b1;
                    else sc_frac = sc_frac + 1'b1;
                    taken = 1'b1;
                end
                else if (c == mel_pkg::CH_E_LO || c == mel_pkg::CH_E_UP)
                begin
                    sc_mode = SCAN_ESIGN;
                    taken = 1'b1;
                end
            SCAN_ESIGN:
                if (c == mel_pkg::CH_PLUS)
                begin
                    sc_mode = SCAN_EDIG;
                    taken = 1'b1;
                end
                else if (c == mel_pkg::CH_MINUS)
                begin
                    sc_eneg = 1'b1;
                    sc_mode = SCAN_EDIG;
                    taken = 1'b1;
                end
                else if (dig)
                begin
                    add_exp_digit(c - mel_pkg::CH_ZERO);
                    sc_mode = SCAN_EDIG;
                    taken = 1'b1;
                end
            SCAN_EDIG:
                if (dig)
                begin
                    add_exp_digit(c - mel_pkg::CH_ZERO);
                    taken = 1'b1;
                end
            default: taken = 1'b0;
        endcase
    endtask

    // Advances the scanner by one byte and queues the tokens it completes.
    task automatic scan_byte(input logic [7:0] c);
        token_t           t0;
        token_t           t1;
        int               n;
        char_cls_t        cls;
        logic             taken;
        logic [POS_W-1:0] cur;
        logic [POS_W-1:0] oplen;
        cls = classify(c);
        cur = sc_pos;
        n = 0;
        t0 = '0;
        t1 = '0;
        if (sc_mode != SCAN_IDLE)
        begin
            try_extend(c, cls, taken);
            if (taken)
            begin
                sc_len = sat_inc(sc_len);
                sc_pos = sat_inc(cur);
                return;
            end
            if (sc_mode == SCAN_OP)
            begin
                oplen = sc_eqrun;
                t0 = plain_token(mel_pkg::KIND_OP, sc_start, oplen + 1'b1, sc_first,
                                 sc_eqrun);
            end
            else if (sc_mode == SCAN_IDENT)
                t0 = plain_token((cls == CLS_OPEN) ? mel_pkg::KIND_FUNC : mel_pkg::KIND_VAR,
                                 sc_start, sc_len, 8'h00, 8'h00);
            else
                t0 = number_token();
            n = 1;
            sc_mode = SCAN_IDLE;
        end
        if (cls == CLS_NUL)
        begin
            t1 = plain_token(mel_pkg::KIND_END, cur, '0, 8'h00, 8'h00);
            n = n + 1;
            sc_pos = '0;
        end
        else
        begin
            case (cls)
                CLS_SPACE: ;
                CLS_OPER:
                begin
                    sc_mode  = SCAN_OP;
                    sc_first = c;
                    sc_eqrun = '0;
                    sc_start = cur;
                    sc_len   = POS_W'(1);
                end
                CLS_OPEN:
                begin
                    t1 = plain_token(mel_pkg::KIND_OPEN, cur, POS_W'(1), c, 8'h00);
                    n = n + 1;
                end
                CLS_CLOSE:
                begin
                    t1 = plain_token(mel_pkg::KIND_CLOSE, cur, POS_W'(1), c, 8'h00);
                    n = n + 1;
                end
                CLS_COMMA:
                begin
                    t1 = plain_token(mel_pkg::KIND_COMMA, cur, POS_W'(1), 8'h00, 8'h00);
                    n = n + 1;
                end
                CLS_ALPHA:
                begin
                    sc_mode  = SCAN_IDENT;
                    sc_start = cur;
                    sc_len   = POS_W'(1);
                end
                CLS_DIGIT:
                begin
                    begin_number(cur);
                    sc_mant = MANT_W'(c - mel_pkg::CH_ZERO);
                    sc_mode = SCAN_INT;
                end
                CLS_DOT:
                begin
                    begin_number(cur);
                    sc_mode = SCAN_FRAC;
                end
                default:
                begin
                    t1 = plain_token(mel_pkg::KIND_INVALID, cur, POS_W'(1), c, 8'h00);
                    n = n + 1;
                end
            endcase
            sc_pos = sat_inc(cur);
        end
        // t0 is the closed pending token, t1 the token of this byte itself
        if (n == 2)
        begin
            t1.last = 1'b1;
            token_q.push_back(t0);
            token_q.push_back(t1);
        end
        else if (n == 1)
        begin
            if (sc_mode == SCAN_IDLE && t0.kind == mel_pkg::KIND_OP && t1 == '0
                && cls != CLS_NUL && t0.len != 0)
            begin
                t0.last = 1'b1;
                token_q.push_back(t0);
            end
            else if (t1 != '0 || cls == CLS_NUL)
            begin
                t1.last = 1'b1;
                token_q.push_back(t1);
            end
            else
            begin
                t0.last = 1'b1;
                token_q.push_back(t0);
            end
        end
    endtask

    task automatic check_token();
        token_t got;
        token_t want;
        got.kind  = mel_pkg::kind_t'(token_kind);
        got.start = start_pos;
        got.len   = token_length;
        got.lead  = lead_char;
        got.eq    = equals_count;
        got.mant  = mantissa;
        got.frac  = frac_digits;
        got.expo  = exponent;
        got.ovf   = number_overflow;
        got.last  = last_of_input;
        if (token_q.size() == 0)
        begin
            if (mismatch_count < 10)
                $display("ERROR %0t: token with nothing expected: kind=%0d start=%0d len=%0d",
                         $realtime, got.kind, got.start, got.len);
            mismatch_count++;
        end
        else
        begin
            want = token_q.pop_front();
            if (got.kind !== want.kind || got.start !== want.start || got.len !== want.len
                || got.lead !== want.lead || got.eq !== want.eq || got.mant !== want.mant
                || got.frac !== want.frac || got.expo !== want.expo || got.ovf !== want.ovf
                || got.last !== want.last)
            begin
                if (mismatch_count < 10)
                begin
                    $display("ERROR %0t: exp kind=%0d start=%0d len=%0d lead=%0h eq=%0d",
                             $realtime, want.kind, want.start, want.len, want.lead, want.eq);
                    $display("    mant=%0d frac=%0d exp=%0d ovf=%0b last=%0b",
                             want.mant, want.frac, want.expo, want.ovf, want.last);
                    $display("  got kind=%0d start=%0d len=%0d lead=%0h eq=%0d",
                             got.kind, got.start, got.len, got.lead, got.eq);
                    $display("    mant=%0d frac=%0d exp=%0d ovf=%0b last=%0b",
                             got.mant, got.frac, got.expo, got.ovf, got.last);
                end
                mismatch_count++;
            end
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            char_code <= 8'h00;
            gap_cnt   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                scan_byte(char_code);
            if (!(in_valid && in_stall))
            begin
                if (gap_cnt != 0)
                begin
                    gap_cnt  <= gap_cnt - 1;
                    in_valid <= 1'b0;
                end
                else if (text_q.size() != 0)
                begin
                    in_valid  <= 1'b1;
                    char_code <= text_q.pop_front();
                    gap_cnt   <= draw_wait();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin : receiver
        int hold_draw;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt  <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            check_token();
            hold_draw = draw_wait();
            hold_cnt  <= hold_draw;
            out_stall <= (hold_draw != 0);
        end
        else if (hold_cnt > 1)
            hold_cnt <= hold_cnt - 1;
        else
        begin
            hold_cnt  <= 0;
            out_stall <= 1'b0;
        end
    end

    task automatic push_byte(input logic [7:0] b);
        text_q.push_back(b);
        pushed_bytes++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic drain();
        while (text_q.size() != 0 || in_valid || token_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(mel_pkg::CH_ZERO + $urandom_range(0, 9));
    endfunction

    task automatic gen_number();
        int nd;
        int fd;
        int ed;
        int i;
        nd = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 18) : $urandom_range(0, 4);
        for (i = 0; i < nd; i++)
            push_byte(rand_digit());
        if (nd == 0 || $urandom_range(0, 2) == 0)
        begin
            push_byte(mel_pkg::CH_DOT);
            fd = $urandom_range(0, 4);
            for (i = 0; i < fd; i++)
                push_byte(rand_digit());
        end
        if ($urandom_range(0, 3) == 0)
        begin
            push_byte($urandom_range(0, 1) ? mel_pkg::CH_E_LO : mel_pkg::CH_E_UP);
            case ($urandom_range(0, 2))
                0: push_byte(mel_pkg::CH_PLUS);
                1: push_byte(mel_pkg::CH_MINUS);
                default: ;
            endcase
            ed = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(0, 3);
            for (i = 0; i < ed; i++)
                push_byte(rand_digit());
        end
    endtask

    task automatic gen_ident();
        int nc;
        int i;
        push_byte($urandom_range(0, 1) ? 8'(mel_pkg::CH_A_LO + $urandom_range(0, 25))
                                       : 8'(mel_pkg::CH_A_UP + $urandom_range(0, 25)));
        nc = $urandom_range(0, 5);
        for (i = 0; i < nc; i++)
        begin
            case ($urandom_range(0, 3))
                0: push_byte(8'(mel_pkg::CH_A_LO + $urandom_range(0, 25)));
                1: push_byte(8'(mel_pkg::CH_A_UP + $urandom_range(0, 25)));
                2: push_byte(rand_digit());
                default: push_byte(mel_pkg::CH_UNDER);
            endcase
        end
        if ($urandom_range(0, 2) == 0)
            push_byte(mel_pkg::CH_LPAREN);
    endtask

    task automatic gen_expr();
        int pieces;
        int k;
        int sel;
        int neq;
        pieces = $urandom_range(1, 12);
        for (k = 0; k < pieces; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 20)
                gen_number();
            else if (sel < 35)
                gen_ident();
            else if (sel < 55)
            begin
                push_byte(oper_text[$urandom_range(0, 11)]);
                sel = $urandom_range(0, 9);
                neq = (sel < 6) ? 0 : (sel < 9) ? 1 : 3;
                repeat (neq) push_byte(mel_pkg::CH_EQ);
            end
            else if (sel < 65)
            begin
                case ($urandom_range(0, 2))
                    0: push_byte(mel_pkg::CH_LPAREN);
                    1: push_byte(mel_pkg::CH_LBRACK);
                    default: push_byte(mel_pkg::CH_LBRACE);
                endcase
            end
            else if (sel < 75)
            begin
                case ($urandom_range(0, 2))
                    0: push_byte(mel_pkg::CH_RPAREN);
                    1: push_byte(mel_pkg::CH_RBRACK);
                    default: push_byte(mel_pkg::CH_RBRACE);
                endcase
            end
            else if (sel < 80)
                push_byte(mel_pkg::CH_COMMA);
            else if (sel < 90)
                repeat ($urandom_range(1, 3)) push_byte(mel_pkg::CH_SPACE);
            else
                push_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 9) < 3)
                push_byte(mel_pkg::CH_SPACE);
        end
        if ($urandom_range(0, 19) != 0)
            push_byte(mel_pkg::CH_NUL);
    endtask

    initial
    begin : stimulus
        logic paused_mid;
        paused_mid = 1'b0;
        while (!rst_n) @(negedge clk);
        @(negedge clk);

        // directed
        push_byte(mel_pkg::CH_NUL);
        push_text("a_1(");
        push_text("-==");
        push_text(")");
        push_text(".,");
        push_text("2.5.3");
        push_text("7E-]");
        push_byte(8'hFF);
        push_byte(8'h80);
        push_text("x");
        push_byte(mel_pkg::CH_NUL);
        drain();

        // saturation of mantissa, fraction count, exponent and '=' run
        push_text("123456789012345678901 ");
        push_byte(mel_pkg::CH_DOT);
        repeat (260) push_byte(mel_pkg::CH_ZERO);
        push_text(" 1e-99999 <");
        repeat (300) push_byte(mel_pkg::CH_EQ);
        push_text("1");
        push_byte(mel_pkg::CH_NUL);
        drain();

        // random expressions
        while (pushed_bytes < 1550)
        begin
            while (text_q.size() > 2) @(negedge clk);
            if (!paused_mid && pushed_bytes > 800)
            begin
                drain();
                paused_mid = 1'b1;
            end
            quiet = ($urandom_range(0, 5) == 0);
            gen_expr();
        end
        push_byte(mel_pkg::CH_NUL);
        drain();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && token_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule
